// ===== sv/mbb_pkg.sv =====
// Shared types and constants for the mesh bounding box / sphere block.
`timescale 1ns / 1ps
package mbb_pkg;

    localparam logic signed [31:0] POS_MOST = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] NEG_MOST = 32'sh8000_0000;
    localparam int SQRT_STEPS = 32;
    localparam logic [2:0] REG_BOUND_MODE = 3'd0;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic               last_vertex;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] min_x;
        logic signed [31:0] min_y;
        logic signed [31:0] min_z;
        logic signed [31:0] max_x;
        logic signed [31:0] max_y;
        logic signed [31:0] max_z;
        logic signed [31:0] center_x;
        logic signed [31:0] center_y;
        logic signed [31:0] center_z;
        logic        [32:0] radius;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CENTER,
        ST_SWEEP,
        ST_DRAIN,
        ST_SQRT,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic accept;     // take a vertex
        logic box_out;    // emit box result and clear
        logic center_en;  // compute sphere centre
        logic sweep_init; // zero read address and best distance
        logic rd_en;      // issue one store read
        logic sqrt_init;  // load root unit
        logic sqrt_step;  // one root iteration
        logic sphere_out; // emit sphere result and clear
    } t_cmd;

    typedef struct packed {
        logic rd_last;
        logic pipe_busy;
        logic sqrt_last;
    } t_sts;

endpackage

// ===== sv/mbb_ctrl.sv =====
// Controller state machine: vertex load, sphere sweep and square root sequencing.
`timescale 1ns / 1ps
module mbb_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic          i_last,
    input  logic          i_mode,
    input  mbb_pkg::t_sts i_sts,
    output mbb_pkg::t_cmd o_cmd,
    output logic          o_busy
);
    import mbb_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_busy  = 1'b1;
        case (r_state)
            ST_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    o_cmd.accept = 1'b1;
                    if (i_last && !i_mode) begin
                        o_cmd.box_out = 1'b1;
                    end else if (i_last) begin
                        n_state = ST_CENTER;
                    end
                end
            end
            ST_CENTER: begin
                o_cmd.center_en  = 1'b1;
                o_cmd.sweep_init = 1'b1;
                n_state          = ST_SWEEP;
            end
            ST_SWEEP: begin
                o_cmd.rd_en = 1'b1;
                if (i_sts.rd_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!i_sts.pipe_busy) begin
                    o_cmd.sqrt_init = 1'b1;
                    n_state         = ST_SQRT;
                end
            end
            ST_SQRT: begin
                o_cmd.sqrt_step = 1'b1;
                if (i_sts.sqrt_last) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                o_cmd.sphere_out = 1'b1;
                n_state          = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

`ifndef ASSERT_OFF
    a_sphere_go: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.accept && i_last && i_mode) |=> (r_state == ST_CENTER))
        else $error("sphere mesh end did not start the centre step");
    a_sqrt_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SQRT && i_sts.sqrt_last) |=> (r_state == ST_OUT))
        else $error("root unit finished without output");
    a_out_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT) |=> (r_state == ST_IDLE && !o_busy))
        else $error("block not idle after sphere output");
`endif

endmodule

// ===== sv/mbb_dp.sv =====
// Datapath: running extremes, vertex store, distance pipeline and root unit.
`timescale 1ns / 1ps
module mbb_dp #(
    parameter int MAX_VERTICES = 4096
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  mbb_pkg::t_in_item  i_item,
    input  mbb_pkg::t_cmd      i_cmd,
    output mbb_pkg::t_sts      o_sts,
    output mbb_pkg::t_out_item o_result,
    output logic               o_done
);
    import mbb_pkg::*;

    localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int CW = $clog2(MAX_VERTICES + 1);
    localparam logic [CW-1:0] FULL = CW'(MAX_VERTICES);

    logic [95:0] mem [MAX_VERTICES];

    logic [CW-1:0]      r_count;
    logic signed [31:0] r_min [3];
    logic signed [31:0] r_max [3];
    logic signed [31:0] n_min [3];
    logic signed [31:0] n_max [3];
    logic signed [31:0] r_ctr [3];
    logic signed [31:0] pos [3];
    logic [AW-1:0]      r_addr;
    logic [95:0]        r_rd_data;
    logic               r_v1, r_v2, r_v3;
    logic [31:0]        r_ad [3];
    logic [63:0]        r_sq [3];
    logic [63:0]        r_best;
    logic [63:0]        r_rest, r_root, r_bit;
    logic [4:0]         r_step;
    logic [63:0]        trial;
    logic [63:0]        sq_sum;

    assign pos[0] = i_item.pos_x;
    assign pos[1] = i_item.pos_y;
    assign pos[2] = i_item.pos_z;

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            n_min[a] = (pos[a] < r_min[a]) ? pos[a] : r_min[a];
            n_max[a] = (pos[a] > r_max[a]) ? pos[a] : r_max[a];
        end
    end

    assign trial  = r_root + r_bit;
    assign sq_sum = r_sq[0] + r_sq[1] + r_sq[2];

    assign o_sts.rd_last   = ({{(CW - AW){1'b0}}, r_addr} == r_count - CW'(1));
    assign o_sts.pipe_busy = r_v1 | r_v2 | r_v3;
    assign o_sts.sqrt_last = (r_step == 5'(SQRT_STEPS - 1));

    // store write and sweep read
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && r_count != FULL) begin
            mem[r_count[AW-1:0]] <= {i_item.pos_x, i_item.pos_y, i_item.pos_z};
        end
        r_rd_data <= mem[r_addr];
    end

    // control-side registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_v3    <= 1'b0;
            o_done  <= 1'b0;
            r_step  <= '0;
            for (int a = 0; a < 3; a++) begin
                r_min[a] <= POS_MOST;
                r_max[a] <= NEG_MOST;
            end
        end else begin
            o_done <= i_cmd.box_out | i_cmd.sphere_out;
            r_v1   <= i_cmd.rd_en;
            r_v2   <= r_v1;
            r_v3   <= r_v2;
            if (i_cmd.sqrt_init) begin
                r_step <= '0;
            end else if (i_cmd.sqrt_step) begin
                r_step <= r_step + 5'd1;
            end
            if (i_cmd.box_out || i_cmd.sphere_out) begin
                r_count <= '0;
                for (int a = 0; a < 3; a++) begin
                    r_min[a] <= POS_MOST;
                    r_max[a] <= NEG_MOST;
                end
            end else if (i_cmd.accept) begin
                if (r_count != FULL) begin
                    r_count <= r_count + CW'(1);
                end
                for (int a = 0; a < 3; a++) begin
                    r_min[a] <= n_min[a];
                    r_max[a] <= n_max[a];
                end
            end
        end
    end

    // centre, distance pipeline, root unit and result register
    always_ff @(posedge i_clk) begin
        logic signed [32:0] s;
        logic signed [32:0] d;
        if (i_cmd.center_en) begin
            for (int a = 0; a < 3; a++) begin
                s        = 33'(r_min[a]) + 33'(r_max[a]);
                r_ctr[a] <= 32'(s >>> 1);
            end
        end
        if (i_cmd.sweep_init) begin
            r_addr <= '0;
        end else if (i_cmd.rd_en) begin
            r_addr <= r_addr + AW'(1);
        end
        for (int a = 0; a < 3; a++) begin
            d       = 33'($signed(r_rd_data[95 - 32*a -: 32])) - 33'(r_ctr[a]);
            r_ad[a] <= d[32] ? 32'(-d) : 32'(d);
            r_sq[a] <= 64'(r_ad[a]) * 64'(r_ad[a]);
        end
        if (i_cmd.sweep_init) begin
            r_best <= '0;
        end else if (r_v3 && sq_sum > r_best) begin
            r_best <= sq_sum;
        end
        if (i_cmd.sqrt_init) begin
            r_rest <= r_best;
            r_root <= '0;
            r_bit  <= 64'h4000_0000_0000_0000;
        end else if (i_cmd.sqrt_step) begin
            if (r_rest >= trial) begin
                r_rest <= r_rest - trial;
                r_root <= (r_root >> 1) + r_bit;
            end else begin
                r_root <= r_root >> 1;
            end
            r_bit <= r_bit >> 2;
        end
        if (i_cmd.box_out) begin
            o_result          <= '0;
            o_result.min_x    <= n_min[0];
            o_result.min_y    <= n_min[1];
            o_result.min_z    <= n_min[2];
            o_result.max_x    <= n_max[0];
            o_result.max_y    <= n_max[1];
            o_result.max_z    <= n_max[2];
        end else if (i_cmd.sphere_out) begin
            o_result          <= '0;
            o_result.center_x <= r_ctr[0];
            o_result.center_y <= r_ctr[1];
            o_result.center_z <= r_ctr[2];
            o_result.radius   <= r_root[32:0];
        end
    end

`ifndef ASSERT_OFF
    a_rd_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rd_en |-> ({{(CW - AW){1'b0}}, r_addr} < r_count))
        else $error("sweep read beyond stored vertices");
    a_pipe_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.sqrt_init |-> !(r_v1 || r_v2 || r_v3))
        else $error("root started before sweep drained");
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (r_count == '0))
        else $error("mesh state not cleared after result");
`endif

endmodule

// ===== sv/mesh_bounding_box_or_sphere.sv =====
// Top level: configuration port, controller and datapath of the mesh bound block.
`timescale 1ns / 1ps
// Vertices are taken one per cycle while busy is low; each result appears on
// o_result with o_done high for a single cycle and cannot be held off. In box
// mode the result is registered and appears in the cycle after the last vertex;
// loading continues at once. In sphere mode busy stays high after the last
// vertex (N stored vertices) through the centre step, N store reads, the drain
// of the four-stage distance pipeline, 32 steps of the bit-pair square root
// and the output step. bound_mode is sampled when the last vertex is taken.
module mesh_bounding_box_or_sphere #(
    parameter int MAX_VERTICES = 4096
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  mbb_pkg::t_in_item  i_item,
    output mbb_pkg::t_out_item o_result,
    output logic               o_done,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import mbb_pkg::*;

    logic r_mode;
    t_cmd cmd;
    t_sts sts;

    assign pready = 1'b1;
    assign prdata = (paddr == REG_BOUND_MODE) ? {31'd0, r_mode} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
        end else if (psel && penable && pwrite && paddr == REG_BOUND_MODE) begin
            r_mode <= pwdata[0];
        end
    end

    mbb_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_last  (i_item.last_vertex),
        .i_mode  (r_mode),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    mbb_dp #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_cmd    (cmd),
        .o_sts    (sts),
        .o_result (o_result),
        .o_done   (o_done)
    );

endmodule
